### src/box_circle_contact_macros.svh
// Assertion macros used by the checker file bcc_checker.sv.
// No dependencies; expects clk and arst_n in the including scope.
`ifndef BOX_CIRCLE_CONTACT_MACROS_SVH
`define BOX_CIRCLE_CONTACT_MACROS_SVH

// implication checked on every clock, held off while in reset
`define BCC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition that must never be seen
`define BCC_ASSERT_NEVER(label, cond, msg) \
	`BCC_ASSERT_IMP(label, 1'b1, !(cond), msg)

`endif

### src/bcc_pkg.sv
// Types and constants of the box/circle contact pipeline.
// No dependencies.
`timescale 1ns / 1ps

package bcc_pkg;

	localparam int POS_W   = 32;
	localparam int EXT_W   = 30;
	localparam int DX_W    = 35;
	localparam int RV_W    = 33;
	localparam int SQ_W    = 2 * EXT_W;
	localparam int REM_W   = EXT_W + 2;
	localparam int NL_W    = 17;
	localparam int Q_W     = 17;
	localparam int NUM_W   = EXT_W + NL_W;
	localparam int NRM_W   = 18;
	localparam int PRD_W   = RV_W + NRM_W;
	localparam int DOT_W   = PRD_W + 1;
	localparam int DEP_W   = 31;
	localparam int SEP_W   = 32;
	localparam int NSHIFT  = 16;
	localparam int SQ_CELLS  = EXT_W;
	localparam int DIV_CELLS = Q_W;
	localparam int LATENCY = 5 + SQ_CELLS + 1 + DIV_CELLS + 4;

	typedef struct packed {
		logic                    vld;
		logic                    nohit;
		logic                    degen;
		logic [EXT_W-1:0]        r;
		logic                    sgnx;
		logic                    sgny;
		logic [EXT_W-1:0]        magx;
		logic [EXT_W-1:0]        magy;
		logic signed [RV_W-1:0]  rx;
		logic signed [RV_W-1:0]  ry;
		logic [SQ_W-1:0]         sq;
		logic [REM_W-1:0]        rem;
		logic [EXT_W-1:0]        root;
		logic [EXT_W-1:0]        depth;
		logic [EXT_W-1:0]        remx;
		logic [EXT_W-1:0]        remy;
		logic [NL_W-1:0]         nlox;
		logic [NL_W-1:0]         nloy;
		logic [Q_W-1:0]          qx;
		logic [Q_W-1:0]          qy;
	} item_t;

endpackage

### src/bcc_sqrt_cell.sv
// One digit of the integer square root chain: two radicand bits in, one root bit out.
// Depends on bcc_pkg.
`timescale 1ns / 1ps

module bcc_sqrt_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  bcc_pkg::item_t d,
	output bcc_pkg::item_t q
);
	import bcc_pkg::*;

	logic [REM_W-1:0] rsh;
	logic [REM_W-1:0] trial;
	logic             take;
	item_t            nxt;
	item_t            pay_q;
	logic             vld_q;

	always_comb begin
		nxt   = d;
		rsh   = {d.rem[REM_W-3:0], d.sq[SQ_W-1 -: 2]};
		trial = {d.root, 2'b01};
		take  = (rsh >= trial);
		nxt.rem  = take ? (rsh - trial) : rsh;
		nxt.root = {d.root[EXT_W-2:0], take};
		nxt.sq   = {d.sq[SQ_W-3:0], 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= d.vld;
		end
	end

	always_ff @(posedge clk) begin
		pay_q <= nxt;
	end

	always_comb begin
		q     = pay_q;
		q.vld = vld_q;
	end

endmodule

### src/bcc_div_cell.sv
// One quotient bit of the two normal-component divisions (x and y lanes).
// Depends on bcc_pkg.
`timescale 1ns / 1ps

module bcc_div_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  bcc_pkg::item_t d,
	output bcc_pkg::item_t q
);
	import bcc_pkg::*;

	logic [EXT_W:0] dv;
	logic [EXT_W:0] tx;
	logic [EXT_W:0] ty;
	logic           takex;
	logic           takey;
	item_t          nxt;
	item_t          pay_q;
	logic           vld_q;

	always_comb begin
		nxt   = d;
		dv    = {1'b0, d.root};
		tx    = {d.remx, d.nlox[NL_W-1]};
		ty    = {d.remy, d.nloy[NL_W-1]};
		takex = (tx >= dv);
		takey = (ty >= dv);
		nxt.remx = takex ? EXT_W'(tx - dv) : tx[EXT_W-1:0];
		nxt.remy = takey ? EXT_W'(ty - dv) : ty[EXT_W-1:0];
		nxt.nlox = {d.nlox[NL_W-2:0], 1'b0};
		nxt.nloy = {d.nloy[NL_W-2:0], 1'b0};
		nxt.qx   = {d.qx[Q_W-2:0], takex};
		nxt.qy   = {d.qy[Q_W-2:0], takey};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= d.vld;
		end
	end

	always_ff @(posedge clk) begin
		pay_q <= nxt;
	end

	always_comb begin
		q     = pay_q;
		q.vld = vld_q;
	end

endmodule

### src/box_circle_contact.sv
// Top level of the box/circle contact test pipeline.
// Depends on bcc_pkg, bcc_sqrt_cell and bcc_div_cell.
//
// Usage:
//   A pair (box corner, half extents, circle corner, radius, two velocities)
//   transfers at a rising edge with start high and busy low. busy is always
//   low: one pair may transfer in every cycle.
//   Each pair gives one result at the end of the chain: done is high for exactly one
//   cycle and hit, degenerate, depth, normal_x, normal_y and sep_velocity are
//   valid in that cycle only. Results leave in transfer order.
//   The chain is made of 5 front stages (centers, clamp, range check,
//   squares, distance compare), 30 square-root cells (one root bit each),
//   one prep stage, 17 divider cells (one normal bit each, x and y lanes) and
//   4 output stages (sign, products, dot sum, rounding and saturation).
//   Throughput is one pair per cycle.
//   The receiver cannot stall; a result is shown once and then gone.
//   Reset clears all valid bits, so done stays low until a pair has gone through.
`timescale 1ns / 1ps

module box_circle_contact (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [bcc_pkg::POS_W-1:0]      box_x,
	input  logic signed [bcc_pkg::POS_W-1:0]      box_y,
	input  logic        [bcc_pkg::EXT_W-1:0]      half_w,
	input  logic        [bcc_pkg::EXT_W-1:0]      half_h,
	input  logic signed [bcc_pkg::POS_W-1:0]      circ_x,
	input  logic signed [bcc_pkg::POS_W-1:0]      circ_y,
	input  logic        [bcc_pkg::EXT_W-1:0]      radius,
	input  logic signed [bcc_pkg::POS_W-1:0]      box_vx,
	input  logic signed [bcc_pkg::POS_W-1:0]      box_vy,
	input  logic signed [bcc_pkg::POS_W-1:0]      circ_vx,
	input  logic signed [bcc_pkg::POS_W-1:0]      circ_vy,
	output logic                                  done,
	output logic                                  hit,
	output logic                                  degenerate,
	output logic        [bcc_pkg::DEP_W-1:0]      depth,
	output logic signed [bcc_pkg::NRM_W-1:0]      normal_x,
	output logic signed [bcc_pkg::NRM_W-1:0]      normal_y,
	output logic signed [bcc_pkg::SEP_W-1:0]      sep_velocity
);
	import bcc_pkg::*;

	localparam logic [DOT_W-1:0] HALF_LSB = DOT_W'(1) << (NSHIFT - 1);
	localparam logic [DOT_W-NSHIFT-1:0] SAT_NEG = (DOT_W-NSHIFT)'(64'h8000_0000);
	localparam logic [DOT_W-NSHIFT-1:0] SAT_POS = (DOT_W-NSHIFT)'(64'h7FFF_FFFF);

	logic                    vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [DX_W-1:0]  dx_s1, dy_s1;
	logic [EXT_W-1:0]        hw_s1, hh_s1, r_s1, r_s2, r_s3, r_s4;
	logic signed [RV_W-1:0]  rx_s1, ry_s1, rx_s2, ry_s2, rx_s3, ry_s3, rx_s4, ry_s4;
	logic signed [DX_W-1:0]  vx_s2, vy_s2;
	logic                    far_s3, far_s4;
	logic                    sgnx_s3, sgny_s3, sgnx_s4, sgny_s4;
	logic [EXT_W-1:0]        magx_s3, magy_s3, magx_s4, magy_s4;
	logic [SQ_W-1:0]         sqx_s4, sqy_s4, rsq_s4;
	item_t                   s5_nxt;
	item_t                   pay_s5;
	item_t                   head;

	logic signed [DX_W-1:0]  hwe, hhe, re, absx, absy;
	logic [SQ_W:0]           sqsum;

	item_t                   sq_chain  [SQ_CELLS+1];
	item_t                   div_chain [DIV_CELLS+1];

	item_t                   prep_nxt, pay_p, prep;
	logic                    vld_p;
	logic [NUM_W-1:0]        numx, numy;

	item_t                   dv;
	logic                    vld_f1, vld_f2, vld_f3, vld_f4;
	logic                    hit_f1, hit_f2, hit_f3;
	logic                    deg_f1, deg_f2, deg_f3;
	logic [EXT_W-1:0]        dep_f1, dep_f2, dep_f3;
	logic signed [NRM_W-1:0] nx_f1, ny_f1, nx_f2, ny_f2, nx_f3, ny_f3;
	logic signed [RV_W-1:0]  rx_f1, ry_f1;
	logic signed [PRD_W-1:0] px_f2, py_f2;
	logic signed [DOT_W-1:0] dot_f3;
	logic [NRM_W-1:0]        qx18, qy18;
	logic [DOT_W-1:0]        dmag, drnd;
	logic [DOT_W-NSHIFT-1:0] rs;
	logic [SEP_W-1:0]        sep_nxt;

	assign busy = 1'b0;

	// front stages
	assign hwe = {{(DX_W-EXT_W){1'b0}}, hw_s1};
	assign hhe = {{(DX_W-EXT_W){1'b0}}, hh_s1};
	assign re  = {{(DX_W-EXT_W){1'b0}}, r_s2};
	assign absx = vx_s2[DX_W-1] ? -vx_s2 : vx_s2;
	assign absy = vy_s2[DX_W-1] ? -vy_s2 : vy_s2;
	assign sqsum = {1'b0, sqx_s4} + {1'b0, sqy_s4};

	always_comb begin
		s5_nxt       = '0;
		s5_nxt.nohit = far_s4 || (sqsum > {1'b0, rsq_s4});
		s5_nxt.degen = (sqsum == '0);
		s5_nxt.r     = r_s4;
		s5_nxt.sgnx  = sgnx_s4;
		s5_nxt.sgny  = sgny_s4;
		s5_nxt.magx  = magx_s4;
		s5_nxt.magy  = magy_s4;
		s5_nxt.rx    = rx_s4;
		s5_nxt.ry    = ry_s4;
		s5_nxt.sq    = sqsum[SQ_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= ({{(DX_W-POS_W){circ_x[POS_W-1]}}, circ_x} + {{(DX_W-EXT_W){1'b0}}, radius})
			- ({{(DX_W-POS_W){box_x[POS_W-1]}}, box_x} + {{(DX_W-EXT_W){1'b0}}, half_w});
		dy_s1 <= ({{(DX_W-POS_W){circ_y[POS_W-1]}}, circ_y} + {{(DX_W-EXT_W){1'b0}}, radius})
			- ({{(DX_W-POS_W){box_y[POS_W-1]}}, box_y} + {{(DX_W-EXT_W){1'b0}}, half_h});
		hw_s1 <= half_w;
		hh_s1 <= half_h;
		r_s1  <= radius;
		rx_s1 <= {circ_vx[POS_W-1], circ_vx} - {box_vx[POS_W-1], box_vx};
		ry_s1 <= {circ_vy[POS_W-1], circ_vy} - {box_vy[POS_W-1], box_vy};

		if (dx_s1 > hwe) begin
			vx_s2 <= dx_s1 - hwe;
		end else if (dx_s1 < -hwe) begin
			vx_s2 <= dx_s1 + hwe;
		end else begin
			vx_s2 <= '0;
		end
		if (dy_s1 > hhe) begin
			vy_s2 <= dy_s1 - hhe;
		end else if (dy_s1 < -hhe) begin
			vy_s2 <= dy_s1 + hhe;
		end else begin
			vy_s2 <= '0;
		end
		r_s2  <= r_s1;
		rx_s2 <= rx_s1;
		ry_s2 <= ry_s1;

		far_s3  <= (vx_s2 > re) || (vx_s2 < -re) || (vy_s2 > re) || (vy_s2 < -re);
		sgnx_s3 <= vx_s2[DX_W-1];
		sgny_s3 <= vy_s2[DX_W-1];
		magx_s3 <= absx[EXT_W-1:0];
		magy_s3 <= absy[EXT_W-1:0];
		r_s3    <= r_s2;
		rx_s3   <= rx_s2;
		ry_s3   <= ry_s2;

		sqx_s4  <= magx_s3 * magx_s3;
		sqy_s4  <= magy_s3 * magy_s3;
		rsq_s4  <= r_s3 * r_s3;
		far_s4  <= far_s3;
		sgnx_s4 <= sgnx_s3;
		sgny_s4 <= sgny_s3;
		magx_s4 <= magx_s3;
		magy_s4 <= magy_s3;
		r_s4    <= r_s3;
		rx_s4   <= rx_s3;
		ry_s4   <= ry_s3;

		pay_s5 <= s5_nxt;
	end

	always_comb begin
		head     = pay_s5;
		head.vld = vld_s5;
	end

	// square-root chain
	assign sq_chain[0] = head;

	for (genvar i = 0; i < SQ_CELLS; i++) begin : g_sqrt
		bcc_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.d      (sq_chain[i]),
			.q      (sq_chain[i+1])
		);
	end

	// prep: depth and division numerators
	always_comb begin
		prep_nxt = sq_chain[SQ_CELLS];
		numx = {prep_nxt.magx, {NSHIFT{1'b0}}} + NUM_W'(prep_nxt.root >> 1);
		numy = {prep_nxt.magy, {NSHIFT{1'b0}}} + NUM_W'(prep_nxt.root >> 1);
		prep_nxt.depth = prep_nxt.r - prep_nxt.root;
		prep_nxt.remx  = numx[NUM_W-1 -: EXT_W];
		prep_nxt.remy  = numy[NUM_W-1 -: EXT_W];
		prep_nxt.nlox  = numx[NL_W-1:0];
		prep_nxt.nloy  = numy[NL_W-1:0];
		prep_nxt.qx    = '0;
		prep_nxt.qy    = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p <= 1'b0;
		end else begin
			vld_p <= sq_chain[SQ_CELLS].vld;
		end
	end

	always_ff @(posedge clk) begin
		pay_p <= prep_nxt;
	end

	always_comb begin
		prep     = pay_p;
		prep.vld = vld_p;
	end

	// divider chain
	assign div_chain[0] = prep;

	for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
		bcc_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.d      (div_chain[i]),
			.q      (div_chain[i+1])
		);
	end

	// output stages
	assign dv   = div_chain[DIV_CELLS];
	assign qx18 = {1'b0, dv.qx};
	assign qy18 = {1'b0, dv.qy};

	always_comb begin
		dmag = dot_f3[DOT_W-1] ? DOT_W'(-dot_f3) : DOT_W'(dot_f3);
		drnd = dmag + HALF_LSB;
		rs   = drnd[DOT_W-1:NSHIFT];
		if (dot_f3[DOT_W-1]) begin
			sep_nxt = (rs > SAT_NEG) ? SAT_NEG[SEP_W-1:0] : SEP_W'(-rs);
		end else begin
			sep_nxt = (rs > SAT_POS) ? SAT_POS[SEP_W-1:0] : rs[SEP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_f1 <= 1'b0;
			vld_f2 <= 1'b0;
			vld_f3 <= 1'b0;
			vld_f4 <= 1'b0;
		end else begin
			vld_f1 <= dv.vld;
			vld_f2 <= vld_f1;
			vld_f3 <= vld_f2;
			vld_f4 <= vld_f3;
		end
	end

	always_ff @(posedge clk) begin
		hit_f1 <= ~dv.nohit;
		deg_f1 <= ~dv.nohit & dv.degen;
		dep_f1 <= dv.nohit ? '0 : dv.depth;
		nx_f1  <= (dv.nohit || dv.degen) ? '0 : (dv.sgnx ? -qx18 : qx18);
		ny_f1  <= (dv.nohit || dv.degen) ? '0 : (dv.sgny ? -qy18 : qy18);
		rx_f1  <= dv.rx;
		ry_f1  <= dv.ry;

		px_f2  <= rx_f1 * nx_f1;
		py_f2  <= ry_f1 * ny_f1;
		hit_f2 <= hit_f1;
		deg_f2 <= deg_f1;
		dep_f2 <= dep_f1;
		nx_f2  <= nx_f1;
		ny_f2  <= ny_f1;

		dot_f3 <= {px_f2[PRD_W-1], px_f2} + {py_f2[PRD_W-1], py_f2};
		hit_f3 <= hit_f2;
		deg_f3 <= deg_f2;
		dep_f3 <= dep_f2;
		nx_f3  <= nx_f2;
		ny_f3  <= ny_f2;

		hit          <= hit_f3;
		degenerate   <= deg_f3;
		depth        <= {{(DEP_W-EXT_W){1'b0}}, dep_f3};
		normal_x     <= nx_f3;
		normal_y     <= ny_f3;
		sep_velocity <= sep_nxt;
	end

	assign done = vld_f4;

endmodule

### src/bcc_checker.sv
// Port-level checks of box_circle_contact, bound to the top level.
// Depends on bcc_pkg and box_circle_contact_macros.svh.
`timescale 1ns / 1ps
`include "box_circle_contact_macros.svh"

module bcc_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  start,
	input logic                                  busy,
	input logic                                  done,
	input logic                                  hit,
	input logic                                  degenerate,
	input logic        [bcc_pkg::DEP_W-1:0]      depth,
	input logic signed [bcc_pkg::NRM_W-1:0]      normal_x,
	input logic signed [bcc_pkg::NRM_W-1:0]      normal_y,
	input logic signed [bcc_pkg::SEP_W-1:0]      sep_velocity
);
	import bcc_pkg::*;

	localparam logic signed [NRM_W-1:0] N_ONE = NRM_W'(65536);

	`BCC_ASSERT_NEVER(a_no_busy, busy, "busy raised")
	`BCC_ASSERT_IMP(a_latency, done, $past(start && !busy, LATENCY), "result without transfer")
	`BCC_ASSERT_IMP(a_miss_zero, done && !hit, (depth == '0) && (normal_x == '0) && (normal_y == '0) && (sep_velocity == '0) && !degenerate, "miss result not zero")
	`BCC_ASSERT_IMP(a_degen, done && degenerate, hit && (normal_x == '0) && (normal_y == '0) && (sep_velocity == '0), "degenerate result wrong")
	`BCC_ASSERT_IMP(a_norm_rng, done, (normal_x <= N_ONE) && (normal_x >= -N_ONE) && (normal_y <= N_ONE) && (normal_y >= -N_ONE), "normal out of range")

endmodule

bind box_circle_contact bcc_checker u_bcc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.hit          (hit),
	.degenerate   (degenerate),
	.depth        (depth),
	.normal_x     (normal_x),
	.normal_y     (normal_y),
	.sep_velocity (sep_velocity)
);
